@@ sv/spq_pkg.sv @@
// Package for the sorted-array priority queue core.
// Holds the sizing constants, command and status codes, FSM state and the
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    // Queue sizing.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // Command codes carried on the input.
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    // Status codes carried on the result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    load;
        logic    insert;
        logic    remove;
        logic    clear;
        logic    read_top;
        t_status status;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

@@ sv/spq_ctrl.sv @@
// Controller state machine for the sorted-array priority queue core.
// Sequences one command per transfer and decodes it into datapath commands.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_ctrl o_ctrl
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a transfer moves the controller to the execute state, which returns to idle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: capture the command when idle, decode it in the execute cycle.
    always_comb begin
        o_ctrl = '0;
        o_ctrl.status = ST_OK;
        busy = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.capture = start;
            end
            S_EXEC: begin
                busy = 1'b1;
                o_ctrl.load = 1'b1;
                case (i_stat.cmd)
                    CMD_ENQUEUE: begin
                        if (i_stat.full) begin
                            o_ctrl.status = ST_FULL;
                        end else begin
                            o_ctrl.insert = 1'b1;
                        end
                    end
                    CMD_DEQUEUE, CMD_PEEK: begin
                        if (i_stat.empty) begin
                            o_ctrl.status = ST_EMPTY;
                        end else begin
                            o_ctrl.read_top = 1'b1;
                            o_ctrl.remove = (i_stat.cmd == CMD_DEQUEUE);
                        end
                    end
                    CMD_CLEAR: begin
                        o_ctrl.clear = 1'b1;
                    end
                    default: begin
                        o_ctrl.load = 1'b1;
                    end
                endcase
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/spq_datapath.sv @@
// Datapath for the sorted-array priority queue core: a row of compare-and-
// shift cells holding the entries in ascending order, plus result registers.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spq_pkg::t_cmd                       i_command,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_value,
    input  spq_pkg::t_dp_ctrl                   i_ctrl,
    output spq_pkg::t_dp_stat                   o_stat,
    output logic                                o_valid,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_result_value,
    output spq_pkg::t_status                    o_status,
    output logic [spq_pkg::COUNT_W-1:0]         o_count
);
    import spq_pkg::*;

    // Captured command.
    t_cmd                      r_cmd;
    logic signed [VALUE_W-1:0] r_value;

    // Entry cells and occupancy.
    logic signed [VALUE_W-1:0] r_entry [CAPACITY];
    logic signed [VALUE_W-1:0] n_entry [CAPACITY];
    logic [OCC_W-1:0]          r_occ;
    logic [OCC_W-1:0]          n_occ;
    logic [CAPACITY-1:0]       ge;
    logic [IDX_W-1:0]          top_idx;
    logic signed [VALUE_W-1:0] top_value;

    // Result registers.
    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_res_value;
    t_status                   r_status;
    logic [COUNT_W-1:0]        r_count;

    // Command capture at the input transfer.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd   <= i_command;
            r_value <= i_value;
        end
    end

    assign o_stat.cmd   = r_cmd;
    assign o_stat.empty = (r_occ == '0);
    assign o_stat.full  = (r_occ == OCC_W'(CAPACITY));

    // Each occupied cell compares its entry with the new value.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = (OCC_W'(i) < r_occ) && (r_entry[i] >= r_value);
        end
    end

    // Insert: a cell whose lower neighbor holds an entry at or above the new value
    // takes that entry; the lowest cell at or above it (or the first free one) takes the new value.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entry[i] = r_entry[i];
            if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
                n_entry[i] = r_entry[(i > 0) ? i - 1 : 0];
            end else if (ge[i] || (OCC_W'(i) == r_occ)) begin
                n_entry[i] = r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

    // The largest entry sits in the top occupied cell.
    assign top_idx   = IDX_W'(r_occ - OCC_W'(1));
    assign top_value = r_entry[top_idx];

    // Occupancy update.
    always_comb begin
        n_occ = r_occ;
        if (i_ctrl.clear) begin
            n_occ = '0;
        end else if (i_ctrl.insert) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (i_ctrl.remove) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_occ   <= n_occ;
            r_valid <= i_ctrl.load;
        end
    end

    // Result registers, shown for one cycle after the execute cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_res_value <= i_ctrl.read_top ? top_value : '0;
            r_status    <= i_ctrl.status;
            r_count     <= COUNT_W'(n_occ);
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_res_value;
    assign o_status       = r_status;
    assign o_count        = r_count;

    // Occupancy never passes the capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy exceeds capacity");

    // An insert grows the queue by one entry.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.insert |=> r_occ == $past(r_occ) + OCC_W'(1))
        else $error("insert did not grow occupancy");

    // A removal shrinks the queue by one entry.
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.remove && !i_ctrl.clear) |=> r_occ == $past(r_occ) - OCC_W'(1))
        else $error("remove did not shrink occupancy");

    // The queue is never modified on a full or empty rejection.
    a_no_update_on_reject: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (i_ctrl.load && i_ctrl.status != ST_OK) |=> $stable(r_occ))
        else $error("rejected command changed occupancy");

endmodule

@@ sv/sorted_array_priority_queue_core.sv @@
// Top level of the sorted-array priority queue core.
// Joins the controller (spq_ctrl) and the datapath (spq_datapath); uses spq_pkg.
//
//   channel   | handshake        | payload
//   ----------+------------------+---------------------------------------
//   command   | start / busy     | i_command, i_value
//   result    | o_valid strobe   | o_result_value, o_status, o_count
//
// A command transfers at an edge with start high and busy low. It executes in
// the next cycle, in which busy is high.
// The result shows for exactly one cycle after that, alongside busy low, so a
// new command can transfer while it is shown. The receiver cannot stall.
// Reset (synchronous, i_rst_n low) empties the queue; no clearing pass.
`timescale 1ns / 1ps

module sorted_array_priority_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_command,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_result_value,
    output logic [1:0]                          o_status,
    output logic [spq_pkg::COUNT_W-1:0]         o_count
);
    import spq_pkg::*;

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;
    t_status  status;

    // Sequencing.
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_ctrl  (dp_ctrl)
    );

    // Entry cells and result registers.
    spq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (t_cmd'(i_command)),
        .i_value        (i_value),
        .i_ctrl         (dp_ctrl),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (status),
        .o_count        (o_count)
    );

    assign o_status = status;

endmodule
